### hdl/cubic_trim_function_generator_top_defines.svh
// ----------------------------------------------------------------------------
// Cubic trim function generator: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CUBIC_TRIM_FUNCTION_GENERATOR_TOP_DEFINES_SVH
`define CUBIC_TRIM_FUNCTION_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define CTFG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTFG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ctfg_pkg.sv
// ----------------------------------------------------------------------------
// Cubic trim function generator: package
// Types, codes and constants shared by controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ctfg_pkg;

  localparam int unsigned REF_W = 32;
  localparam int unsigned UFRAC = 30;

  // register indexes
  localparam logic [2:0] REG_TRIM_CUBIC  = 3'd0;
  localparam logic [2:0] REG_START_REF   = 3'd1;
  localparam logic [2:0] REG_END_REF     = 3'd2;
  localparam logic [2:0] REG_DURATION_US = 3'd3;
  localparam logic [2:0] REG_RATE_LIMIT  = 3'd4;
  localparam logic [2:0] REG_ACCEL_LIMIT = 3'd5;

  // right-hand side scale factors for the duration searches
  localparam logic [42:0] K_LIN      = 43'd1000000;
  localparam logic [42:0] K_CUB_RATE = 43'd3000000;
  localparam logic [42:0] K_ACCEL    = 43'd6000000000000;

  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_DURING = 2'd1;
  localparam logic [1:0] PH_AFTER  = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RATE  = 2'd1;
  localparam logic [1:0] ERR_ACCEL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_RHS_MUL, ST_RHS_ADD, ST_SF, ST_PP, ST_CMP, ST_SDONE,
    ST_CLASSIFY, ST_DIV, ST_U2, ST_U3, ST_PROD, ST_OFF, ST_FIN
  } ctfg_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_SETUP, OP_RHS_MUL, OP_RHS_ADD, OP_SRCH_F, OP_SRCH_PP,
    OP_SRCH_CMP, OP_SRCH_DONE, OP_DIV_INIT, OP_DIV_STEP, OP_U2, OP_U3, OP_PROD,
    OP_OFF, OP_LOAD_OUT
  } ctfg_op_e;

  typedef enum logic [1:0] {
    SRCH_LIN, SRCH_CUB_RATE, SRCH_ACCEL
  } ctfg_srch_e;

  typedef struct packed {
    ctfg_op_e   op;
    ctfg_srch_e srch;
    logic [4:0] cnt;
  } ctfg_cmd_t;

  typedef struct packed {
    logic valid;
    logic need_search;
    logic cubic;
    logic mid_range;
    logic out_free;
  } ctfg_sts_t;

endpackage

`default_nettype wire

### hdl/ctfg_ctrl.sv
// ----------------------------------------------------------------------------
// Cubic trim function generator: controller
// Sequences setup, duration searches, division and result assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfg_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  output logic                      s_tready_o,
  input  wire ctfg_pkg::ctfg_sts_t  sts_i,
  output ctfg_pkg::ctfg_cmd_t       cmd_o
);

  ctfg_pkg::ctfg_state_e state_q, state_d;
  ctfg_pkg::ctfg_srch_e  srch_q, srch_d;
  logic [4:0]            cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctfg_pkg::ST_IDLE;
      srch_q  <= ctfg_pkg::SRCH_LIN;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      srch_q  <= srch_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    srch_d  = srch_q;
    cnt_d   = cnt_q;
    case (state_q)
      ctfg_pkg::ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = sts_i.valid ? ctfg_pkg::ST_CLASSIFY : ctfg_pkg::ST_SETUP;
        end
      end
      ctfg_pkg::ST_SETUP: begin
        if (sts_i.need_search) begin
          state_d = ctfg_pkg::ST_RHS_MUL;
          srch_d  = sts_i.cubic ? ctfg_pkg::SRCH_CUB_RATE : ctfg_pkg::SRCH_LIN;
        end else begin
          state_d = ctfg_pkg::ST_CLASSIFY;
        end
      end
      ctfg_pkg::ST_RHS_MUL: state_d = ctfg_pkg::ST_RHS_ADD;
      ctfg_pkg::ST_RHS_ADD: begin
        state_d = ctfg_pkg::ST_SF;
        cnt_d   = 5'd0;
      end
      ctfg_pkg::ST_SF: state_d = ctfg_pkg::ST_PP;
      ctfg_pkg::ST_PP: state_d = ctfg_pkg::ST_CMP;
      ctfg_pkg::ST_CMP: begin
        if (&cnt_q) begin
          state_d = ctfg_pkg::ST_SDONE;
        end else begin
          state_d = ctfg_pkg::ST_SF;
          cnt_d   = cnt_q + 5'd1;
        end
      end
      ctfg_pkg::ST_SDONE: begin
        if (srch_q == ctfg_pkg::SRCH_CUB_RATE) begin
          srch_d  = ctfg_pkg::SRCH_ACCEL;
          state_d = ctfg_pkg::ST_RHS_MUL;
        end else begin
          state_d = ctfg_pkg::ST_CLASSIFY;
        end
      end
      ctfg_pkg::ST_CLASSIFY: begin
        cnt_d   = 5'd0;
        state_d = sts_i.mid_range ? ctfg_pkg::ST_DIV : ctfg_pkg::ST_FIN;
      end
      ctfg_pkg::ST_DIV: begin
        if (cnt_q == 5'd30) begin
          state_d = ctfg_pkg::ST_U2;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ctfg_pkg::ST_U2:   state_d = ctfg_pkg::ST_U3;
      ctfg_pkg::ST_U3:   state_d = ctfg_pkg::ST_PROD;
      ctfg_pkg::ST_PROD: state_d = ctfg_pkg::ST_OFF;
      ctfg_pkg::ST_OFF:  state_d = ctfg_pkg::ST_FIN;
      ctfg_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = ctfg_pkg::ST_IDLE;
        end
      end
      default: state_d = ctfg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = ctfg_pkg::OP_NONE;
    cmd_o.srch = srch_q;
    cmd_o.cnt  = cnt_q;
    s_tready_o = 1'b0;
    case (state_q)
      ctfg_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.op = ctfg_pkg::OP_CAPTURE;
        end
      end
      ctfg_pkg::ST_SETUP:    cmd_o.op = ctfg_pkg::OP_SETUP;
      ctfg_pkg::ST_RHS_MUL:  cmd_o.op = ctfg_pkg::OP_RHS_MUL;
      ctfg_pkg::ST_RHS_ADD:  cmd_o.op = ctfg_pkg::OP_RHS_ADD;
      ctfg_pkg::ST_SF:       cmd_o.op = ctfg_pkg::OP_SRCH_F;
      ctfg_pkg::ST_PP:       cmd_o.op = ctfg_pkg::OP_SRCH_PP;
      ctfg_pkg::ST_CMP:      cmd_o.op = ctfg_pkg::OP_SRCH_CMP;
      ctfg_pkg::ST_SDONE:    cmd_o.op = ctfg_pkg::OP_SRCH_DONE;
      ctfg_pkg::ST_CLASSIFY: cmd_o.op = ctfg_pkg::OP_DIV_INIT;
      ctfg_pkg::ST_DIV:      cmd_o.op = ctfg_pkg::OP_DIV_STEP;
      ctfg_pkg::ST_U2:       cmd_o.op = ctfg_pkg::OP_U2;
      ctfg_pkg::ST_U3:       cmd_o.op = ctfg_pkg::OP_U3;
      ctfg_pkg::ST_PROD:     cmd_o.op = ctfg_pkg::OP_PROD;
      ctfg_pkg::ST_OFF:      cmd_o.op = ctfg_pkg::OP_OFF;
      ctfg_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.op = ctfg_pkg::OP_LOAD_OUT;
        end
      end
      default: cmd_o.op = ctfg_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/ctfg_dp.sv
// ----------------------------------------------------------------------------
// Cubic trim function generator: datapath
// Config registers, coefficient setup, duration search, divider, polynomial
// evaluation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_trim_function_generator_top_defines.svh"

module ctfg_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_addr_i,
  input  wire logic [31:0]          cfg_wdata_i,
  input  wire logic [31:0]          s_tdata_i,
  input  wire ctfg_pkg::ctfg_cmd_t  cmd_i,
  output ctfg_pkg::ctfg_sts_t       sts_o,
  input  wire logic                 m_tready_i,
  output logic                      m_tvalid_o,
  output logic [31:0]               m_tdata_o,
  output logic [3:0]                m_tuser_o
);

  logic        cubic_q;
  logic [31:0] start_q, end_q, dur_q;
  logic [30:0] rate_q, accel_q;
  logic        valid_q;
  logic        out_valid_q;

  logic [31:0] t_q, dref_q, res_q;
  logic [1:0]  err_q;
  logic [32:0] absd_q, ca_q;
  logic [33:0] la_q;
  logic        neg_q, xneg_q;
  logic [32:0] sum_q;
  logic [64:0] kpl_q;
  logic [43:0] kph_q;
  logic [75:0] rhs_q;
  logic [63:0] f_q;
  logic [62:0] pph_q, ppl_q;
  logic [33:0] rem_q;
  logic [30:0] q_q, u2_q, u3_q;
  logic [64:0] lp_q;
  logic [63:0] cp_q;
  logic [33:0] off_q;
  logic [31:0] tdata_q;
  logic [3:0]  tuser_q;

  logic [32:0] delta, absd;
  logic [42:0] kconst;
  logic [30:0] lim;
  logic [31:0] cand, least, dur_sel;
  logic [94:0] prod;
  logic        t_neg, t_after;
  logic [33:0] xv, dref_x;
  logic [31:0] mag;
  logic [33:0] div_diff;
  logic        div_ge;
  logic [61:0] mul_qq, mul_u2q;
  logic [64:0] off_diff;
  logic [35:0] r2;
  logic [1:0]  err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cubic_q <= 1'b1;
      start_q <= 32'd0;
      end_q   <= 32'd0;
      dur_q   <= 32'd0;
      rate_q  <= 31'd0;
      accel_q <= 31'd0;
      valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ctfg_pkg::REG_TRIM_CUBIC:  cubic_q <= cfg_wdata_i[0];
        ctfg_pkg::REG_START_REF:   start_q <= cfg_wdata_i;
        ctfg_pkg::REG_END_REF:     end_q   <= cfg_wdata_i;
        ctfg_pkg::REG_DURATION_US: dur_q   <= cfg_wdata_i;
        ctfg_pkg::REG_RATE_LIMIT:  rate_q  <= cfg_wdata_i[30:0];
        ctfg_pkg::REG_ACCEL_LIMIT: accel_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
      if (cfg_addr_i <= ctfg_pkg::REG_ACCEL_LIMIT) begin
        valid_q <= 1'b0;
      end
    end else if (cmd_i.op == ctfg_pkg::OP_SETUP) begin
      valid_q <= 1'b1;
    end
  end

  assign delta = {end_q[31], end_q} - {start_q[31], start_q};
  assign absd  = delta[32] ? (33'd0 - delta) : delta;

  always_comb begin
    err_d = ctfg_pkg::ERR_NONE;
    if (dur_q == 32'd0) begin
      if (rate_q == 31'd0) begin
        err_d = ctfg_pkg::ERR_RATE;
      end else if (cubic_q && accel_q == 31'd0) begin
        err_d = ctfg_pkg::ERR_ACCEL;
      end
    end
  end

  always_comb begin
    case (cmd_i.srch)
      ctfg_pkg::SRCH_LIN:      kconst = ctfg_pkg::K_LIN;
      ctfg_pkg::SRCH_CUB_RATE: kconst = ctfg_pkg::K_CUB_RATE;
      default:                 kconst = ctfg_pkg::K_ACCEL;
    endcase
  end

  assign lim   = (cmd_i.srch == ctfg_pkg::SRCH_ACCEL) ? accel_q : rate_q;
  assign cand  = res_q | (32'h8000_0000 >> cmd_i.cnt);
  assign prod  = {pph_q, 32'd0} + {32'd0, ppl_q};
  assign least = (rhs_q == 76'd0) ? 32'd0 : ((&res_q) ? res_q : res_q + 32'd1);

  always_comb begin
    dur_sel = least;
    if (cmd_i.srch == ctfg_pkg::SRCH_ACCEL && dref_q > least) begin
      dur_sel = dref_q;
    end
    if (dur_sel == 32'd0) begin
      dur_sel = 32'd1;
    end
  end

  assign t_neg   = t_q[31];
  assign t_after = !t_q[31] && (t_q >= dref_q);
  assign dref_x  = {2'b00, dref_q};
  assign xv      = {1'b0, t_q, 1'b0} - dref_x;
  assign mag     = xv[33] ? 32'(34'd0 - xv) : xv[31:0];
  assign div_ge  = rem_q >= dref_x;
  assign div_diff = div_ge ? (rem_q - dref_x) : rem_q;
  assign mul_qq  = q_q * q_q;
  assign mul_u2q = u2_q * q_q;
  assign off_diff = lp_q - {1'b0, cp_q};
  assign r2 = ((xneg_q == neg_q) ? ({{3{sum_q[32]}}, sum_q} + {2'b00, off_q})
                                 : ({{3{sum_q[32]}}, sum_q} - {2'b00, off_q})) + 36'd1;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ctfg_pkg::OP_CAPTURE: t_q <= s_tdata_i;
      ctfg_pkg::OP_SETUP: begin
        absd_q <= absd;
        la_q   <= cubic_q ? ({1'b0, absd} + {absd, 1'b0}) : {absd, 1'b0};
        ca_q   <= cubic_q ? absd : 33'd0;
        neg_q  <= delta[32];
        sum_q  <= {start_q[31], start_q} + {end_q[31], end_q};
        err_q  <= err_d;
        dref_q <= dur_q;
      end
      ctfg_pkg::OP_RHS_MUL: begin
        kpl_q <= absd_q * kconst[31:0];
        kph_q <= absd_q * kconst[42:32];
      end
      ctfg_pkg::OP_RHS_ADD: begin
        rhs_q <= {kph_q, 32'd0} + {11'd0, kpl_q};
        res_q <= 32'd0;
      end
      ctfg_pkg::OP_SRCH_F: begin
        case (cmd_i.srch)
          ctfg_pkg::SRCH_LIN:      f_q <= {32'd0, cand};
          ctfg_pkg::SRCH_CUB_RATE: f_q <= {31'd0, cand, 1'b0};
          default:                 f_q <= cand * cand;
        endcase
      end
      ctfg_pkg::OP_SRCH_PP: begin
        pph_q <= f_q[63:32] * lim;
        ppl_q <= f_q[31:0] * lim;
      end
      ctfg_pkg::OP_SRCH_CMP: begin
        if (prod < {19'd0, rhs_q}) begin
          res_q <= cand;
        end
      end
      ctfg_pkg::OP_SRCH_DONE: begin
        dref_q <= (cmd_i.srch == ctfg_pkg::SRCH_CUB_RATE) ? least : dur_sel;
      end
      ctfg_pkg::OP_DIV_INIT: begin
        rem_q  <= {2'b00, mag};
        q_q    <= 31'd0;
        xneg_q <= xv[33];
      end
      ctfg_pkg::OP_DIV_STEP: begin
        rem_q <= {div_diff[32:0], 1'b0};
        q_q   <= {q_q[29:0], div_ge};
      end
      ctfg_pkg::OP_U2: u2_q <= mul_qq[60:30];
      ctfg_pkg::OP_U3: u3_q <= mul_u2q[60:30];
      ctfg_pkg::OP_PROD: begin
        lp_q <= la_q * q_q;
        cp_q <= ca_q * u3_q;
      end
      ctfg_pkg::OP_OFF: off_q <= off_diff[64:31];
      ctfg_pkg::OP_LOAD_OUT: begin
        if (err_q != ctfg_pkg::ERR_NONE) begin
          tdata_q <= 32'd0;
          tuser_q <= {err_q, ctfg_pkg::PH_ERROR};
        end else if (t_neg) begin
          tdata_q <= start_q;
          tuser_q <= {ctfg_pkg::ERR_NONE, ctfg_pkg::PH_BEFORE};
        end else if (t_after) begin
          tdata_q <= end_q;
          tuser_q <= {ctfg_pkg::ERR_NONE, ctfg_pkg::PH_AFTER};
        end else begin
          tdata_q <= r2[32:1];
          tuser_q <= {ctfg_pkg::ERR_NONE, ctfg_pkg::PH_DURING};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == ctfg_pkg::OP_LOAD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.valid       = valid_q;
  assign sts_o.need_search = (err_d == ctfg_pkg::ERR_NONE) && (dur_q == 32'd0);
  assign sts_o.cubic       = cubic_q;
  assign sts_o.mid_range   = (err_q == ctfg_pkg::ERR_NONE) && !t_neg && !t_after;
  assign sts_o.out_free    = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = tuser_q;

  `CTFG_ASSERT_IMP(a_load_into_free, cmd_i.op == ctfg_pkg::OP_LOAD_OUT, !out_valid_q || m_tready_i, "result loaded over an untaken transfer")
  `CTFG_ASSERT_NXT(a_cfg_invalidates, cfg_we_i && cfg_addr_i <= ctfg_pkg::REG_ACCEL_LIMIT, !valid_q, "register write left coefficients valid")
  `CTFG_ASSERT_NXT(a_dur_nonzero, cmd_i.op == ctfg_pkg::OP_SRCH_DONE && cmd_i.srch != ctfg_pkg::SRCH_CUB_RATE, dref_q != 32'd0, "derived duration is zero")
  `CTFG_ASSERT_IMP(a_unit_range, cmd_i.op == ctfg_pkg::OP_U2, q_q <= 31'h4000_0000, "normalised position above one")

endmodule

`default_nettype wire

### hdl/cubic_trim_function_generator_top.sv
// ----------------------------------------------------------------------------
// Cubic trim function generator: top level
// Linear or cubic trim reference from start to end level per time sample.
//
//   Channel   Direction  Transfer               Contents
//   s_axis    in         tvalid & tready        sample_time
//   m_axis    out        tvalid & tready        reference; phase, error_code
//   cfg       in         cfg_we_i high          register index, write data
//
// A sample in the ramp passes capture, classify, 31 divider steps, the U2, U3,
// product and offset stages and the output load; before, after or error skips
// the divider and those stages. The first sample after a register write adds a
// setup step, plus a duration search (two for cubic, one for linear) when the
// duration is derived. The output register lets a new sample be taken while a
// result waits. Asynchronous active-low reset sets control and config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_trim_function_generator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] sample_time
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] reference
  output logic [3:0]       m_axis_tuser    // [1:0] phase, [3:2] error_code
);

  ctfg_pkg::ctfg_cmd_t cmd;
  ctfg_pkg::ctfg_sts_t sts;

  ctfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ctfg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire
